### rtl/core/pvr_pkg.sv
`timescale 1ns / 1ps

package pvr_pkg;

   // record layout
   localparam int unsigned REC_LEN     = 40;
   localparam int unsigned COUNT_W     = 6;
   localparam logic [5:0]  COUNT_MAX   = 6'd63;
   localparam logic [5:0]  REC_LEN_CNT = 6'd40;

   // magic "OROSCUR1" bytes, byte 0 in the low lane
   localparam logic [63:0] MAGIC_WORD = 64'h3152_5543_534F_524F;

   // FNV-1a 64: prime = 2^40 + 0x1B3
   localparam logic [63:0] FNV_BASIS    = 64'hCBF2_9CE4_8422_2325;
   localparam int unsigned FNV_SHIFT    = 40;
   localparam logic [8:0]  FNV_PRIME_LO = 9'h1B3;

   // splitmix64 finalizer
   localparam logic [63:0] MIX_GOLDEN = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [63:0] MIX_MUL1   = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [63:0] MIX_MUL2   = 64'h94D0_49BB_1331_11EB;
   localparam logic [63:0] LEN_WORD   = 64'd40;

   // result codes
   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_EXP_ZERO  = 4'd1;
   localparam logic [3:0] ST_SIZE      = 4'd2;
   localparam logic [3:0] ST_MAGIC     = 4'd3;
   localparam logic [3:0] ST_VERSION   = 4'd4;
   localparam logic [3:0] ST_RESERVED  = 4'd5;
   localparam logic [3:0] ST_NAMESPACE = 4'd6;
   localparam logic [3:0] ST_REV_ZERO  = 4'd7;
   localparam logic [3:0] ST_CHECKSUM  = 4'd8;

   // register file
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 64;
   localparam logic        REG_EXPECTED_NS = 1'b0;
   localparam logic        REG_FORMAT_VER  = 1'b1;

   // byte queue between front and back
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_AW    = 2;
   localparam logic [2:0]  FIFO_FULL  = 3'd4;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic [5:0] pos;
      logic       size_ok;
   } entry_type;

endpackage

### rtl/core/pvr_front.sv
`timescale 1ns / 1ps

module pvr_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_data_byte,
   input  logic                req_last_byte,
   input  logic                q_full,
   output logic                q_push,
   output pvr_pkg::entry_type  q_entry
);
   import pvr_pkg::*;

   logic [5:0] count_ff, count_in;
   logic [5:0] count_next;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   // saturating position; size check is settled here from the count after this byte
   assign count_next = (count_ff < COUNT_MAX) ? count_ff + 6'd1 : count_ff;

   always_comb begin
      q_entry.data    = req_data_byte;
      q_entry.last    = req_last_byte;
      q_entry.pos     = count_ff;
      q_entry.size_ok = (count_next == REC_LEN_CNT);
      count_in        = count_ff;
      if (q_push) begin
         count_in = req_last_byte ? 6'd0 : count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 6'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

### rtl/core/pvr_fifo.sv
`timescale 1ns / 1ps

module pvr_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pvr_pkg::entry_type  push_entry,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output pvr_pkg::entry_type  pop_entry
);
   import pvr_pkg::*;

   entry_type            slot_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]     count_ff, count_in;

   assign full      = (count_ff == FIFO_FULL);
   assign not_empty = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FIFO_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + FIFO_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + (FIFO_AW+1)'(1);
         2'b01:   count_in = count_ff - (FIFO_AW+1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/core/pvr_back.sv
`timescale 1ns / 1ps

module pvr_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_not_empty,
   input  pvr_pkg::entry_type  q_entry,
   output logic                q_pop,
   input  logic [63:0]         expected_namespace,
   input  logic [31:0]         format_version,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [3:0]          rsp_status,
   output logic [63:0]         rsp_revision_out
);
   import pvr_pkg::*;

   localparam logic [2:0] S_BYTE = 3'd0;
   localparam logic [2:0] S_MIX0 = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_MIX1 = 3'd3;
   localparam logic [2:0] S_POST = 3'd4;

   localparam logic [1:0] STEP_LAST = 2'd2;

   logic [2:0]  state_ff, state_in;
   logic [1:0]  step_ff, step_in;
   logic        round_ff, round_in;

   logic [63:0] hash_ff, hash_in;
   logic        magic_ok_ff, magic_ok_in;
   logic        size_ok_ff, size_ok_in;
   logic [31:0] version_ff, version_in;
   logic [31:0] reserved_ff, reserved_in;
   logic [63:0] namespace_ff, namespace_in;
   logic [63:0] revision_ff, revision_in;
   logic [63:0] sum_ff, sum_in;

   logic [63:0] mul_x_ff, mul_x_in;
   logic [63:0] acc_ff, acc_in;

   logic        out_valid_ff, out_valid_in;
   logic [3:0]  out_status_ff, out_status_in;
   logic [63:0] out_rev_ff, out_rev_in;

   logic [63:0] h_x;
   logic [63:0] h_lo_prod;
   logic [63:0] h_next;
   logic [63:0] mix_v;
   logic [63:0] mix_c;
   logic [31:0] op_a, op_b;
   logic [63:0] prod;
   logic [63:0] fin;
   logic        slot_free;
   logic        load_out;
   logic [3:0]  status;

   // hash step: h * prime = (h << 40) + h * 0x1B3
   assign h_x       = hash_ff ^ {56'd0, q_entry.data};
   assign h_lo_prod = h_x * {55'd0, FNV_PRIME_LO};
   assign h_next    = (h_x << FNV_SHIFT) + h_lo_prod;

   assign mix_v = (hash_ff ^ LEN_WORD) + MIX_GOLDEN;
   assign mix_c = round_ff ? MIX_MUL2 : MIX_MUL1;

   // 64x64 low product from three 32x32 partial products, one a cycle
   always_comb begin
      case (step_ff)
         2'd0:    begin op_a = mul_x_ff[31:0];  op_b = mix_c[31:0];  end
         2'd1:    begin op_a = mul_x_ff[31:0];  op_b = mix_c[63:32]; end
         default: begin op_a = mul_x_ff[63:32]; op_b = mix_c[31:0];  end
      endcase
   end
   assign prod = {32'd0, op_a} * {32'd0, op_b};

   assign fin       = acc_ff ^ (acc_ff >> 31);
   assign slot_free = !out_valid_ff || rsp_ready;
   assign load_out  = (state_ff == S_POST) && slot_free;
   assign q_pop     = (state_ff == S_BYTE) && q_not_empty;

   always_comb begin
      if (expected_namespace == 64'd0)         status = ST_EXP_ZERO;
      else if (!size_ok_ff)                    status = ST_SIZE;
      else if (!magic_ok_ff)                   status = ST_MAGIC;
      else if (version_ff != format_version)   status = ST_VERSION;
      else if (reserved_ff != 32'd0)           status = ST_RESERVED;
      else if (namespace_ff != expected_namespace) status = ST_NAMESPACE;
      else if (revision_ff == 64'd0)           status = ST_REV_ZERO;
      else if (fin != sum_ff)                  status = ST_CHECKSUM;
      else                                     status = ST_OK;
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      round_in      = round_ff;
      hash_in       = hash_ff;
      magic_ok_in   = magic_ok_ff;
      size_ok_in    = size_ok_ff;
      version_in    = version_ff;
      reserved_in   = reserved_ff;
      namespace_in  = namespace_ff;
      revision_in   = revision_ff;
      sum_in        = sum_ff;
      mul_x_in      = mul_x_ff;
      acc_in        = acc_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_status_in = out_status_ff;
      out_rev_in    = out_rev_ff;

      case (state_ff)
         S_BYTE: begin
            if (q_pop) begin
               if (!q_entry.pos[5]) begin
                  hash_in = h_next;
               end
               case (q_entry.pos[5:3])
                  3'd0: begin
                     if (q_entry.data != MAGIC_WORD[{q_entry.pos[2:0], 3'b000} +: 8]) begin
                        magic_ok_in = 1'b0;
                     end
                  end
                  3'd1: begin
                     if (q_entry.pos[2]) begin
                        reserved_in[{q_entry.pos[1:0], 3'b000} +: 8] = q_entry.data;
                     end else begin
                        version_in[{q_entry.pos[1:0], 3'b000} +: 8] = q_entry.data;
                     end
                  end
                  3'd2:    namespace_in[{q_entry.pos[2:0], 3'b000} +: 8] = q_entry.data;
                  3'd3:    revision_in[{q_entry.pos[2:0], 3'b000} +: 8] = q_entry.data;
                  3'd4:    sum_in[{q_entry.pos[2:0], 3'b000} +: 8] = q_entry.data;
                  default: ;  // past the record: not stored
               endcase
               if (q_entry.last) begin
                  size_ok_in = q_entry.size_ok;
                  state_in   = S_MIX0;
               end
            end
         end
         S_MIX0: begin
            mul_x_in = mix_v ^ (mix_v >> 30);
            round_in = 1'b0;
            step_in  = 2'd0;
            state_in = S_MUL;
         end
         S_MUL: begin
            if (step_ff == 2'd0) begin
               acc_in = prod;
            end else begin
               acc_in = acc_ff + {prod[31:0], 32'd0};
            end
            step_in = step_ff + 2'd1;
            if (step_ff == STEP_LAST) begin
               state_in = round_ff ? S_POST : S_MIX1;
            end
         end
         S_MIX1: begin
            mul_x_in = acc_ff ^ (acc_ff >> 27);
            round_in = 1'b1;
            step_in  = 2'd0;
            state_in = S_MUL;
         end
         S_POST: begin
            if (slot_free) begin
               out_valid_in  = 1'b1;
               out_status_in = status;
               out_rev_in    = (status == ST_OK) ? revision_ff : 64'd0;
               hash_in       = FNV_BASIS;
               magic_ok_in   = 1'b1;
               version_in    = 32'd0;
               reserved_in   = 32'd0;
               namespace_in  = 64'd0;
               revision_in   = 64'd0;
               sum_in        = 64'd0;
               state_in      = S_BYTE;
            end
         end
         default: state_in = S_BYTE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_BYTE;
         step_ff       <= 2'd0;
         round_ff      <= 1'b0;
         out_valid_ff  <= 1'b0;
         hash_ff       <= FNV_BASIS;
         magic_ok_ff   <= 1'b1;
         size_ok_ff    <= 1'b0;
         version_ff    <= 32'd0;
         reserved_ff   <= 32'd0;
         namespace_ff  <= 64'd0;
         revision_ff   <= 64'd0;
         sum_ff        <= 64'd0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         round_ff      <= round_in;
         out_valid_ff  <= out_valid_in;
         hash_ff       <= hash_in;
         magic_ok_ff   <= magic_ok_in;
         size_ok_ff    <= size_ok_in;
         version_ff    <= version_in;
         reserved_ff   <= reserved_in;
         namespace_ff  <= namespace_in;
         revision_ff   <= revision_in;
         sum_ff        <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_x_ff      <= mul_x_in;
      acc_ff        <= acc_in;
      out_status_ff <= out_status_in;
      out_rev_ff    <= out_rev_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_revision_out = out_rev_ff;

`ifndef SYNTHESIS
   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == S_BYTE)
      else $error("queue popped while finalizing");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MUL |-> step_ff != 2'd3)
      else $error("multiply step out of range");

   a_ok_has_rev: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OK |-> rsp_revision_out != 64'd0)
      else $error("ok result with zero revision");

   a_clear_after_load: assert property (@(posedge clock) disable iff (reset)
      load_out |=> rsp_valid && hash_ff == FNV_BASIS && magic_ok_ff && state_ff == S_BYTE)
      else $error("record state not cleared after result");
`endif

endmodule

### rtl/core/pointer_record_verifier.sv
`timescale 1ns / 1ps
// rsp_valid rises once the item carrying last_byte has passed the byte queue and the back
//   end has run the splitmix64 finalizer on the shared 32x32 multiplier and then S_POST.
// Throughput: one byte per cycle inside a record while the back end waits in S_BYTE.
// A 4-entry byte queue lets the front keep accepting while the back finalizes.
// Reset (synchronous, active high) empties the queue and output, restarts the record,
//   and sets expected_namespace to 0 and format_version to 1.
module pointer_record_verifier (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_data_byte,
   input  logic                               req_last_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [3:0]                         rsp_status,
   output logic [63:0]                        rsp_revision_out,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [pvr_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [pvr_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [pvr_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);
   import pvr_pkg::*;

   logic [63:0] exp_ns_ff, exp_ns_in;
   logic [31:0] fmt_ver_ff, fmt_ver_in;
   logic        csr_wr;
   logic        reg_sel;

   logic        q_push, q_full, q_pop, q_not_empty;
   entry_type   push_entry, pop_entry;

   // registers sit 8 bytes apart
   assign reg_sel = paddr[3];
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign prdata  = (reg_sel == REG_FORMAT_VER) ? {32'd0, fmt_ver_ff} : exp_ns_ff;

   always_comb begin
      exp_ns_in  = exp_ns_ff;
      fmt_ver_in = fmt_ver_ff;
      if (csr_wr) begin
         case (reg_sel)
            REG_EXPECTED_NS: exp_ns_in  = pwdata;
            REG_FORMAT_VER:  fmt_ver_in = pwdata[31:0];
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ns_ff  <= 64'd0;
         fmt_ver_ff <= 32'd1;
      end else begin
         exp_ns_ff  <= exp_ns_in;
         fmt_ver_ff <= fmt_ver_in;
      end
   end

   pvr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (push_entry)
   );

   pvr_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .pop_entry  (pop_entry)
   );

   pvr_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_not_empty        (q_not_empty),
      .q_entry            (pop_entry),
      .q_pop              (q_pop),
      .expected_namespace (exp_ns_ff),
      .format_version     (fmt_ver_ff),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_revision_out   (rsp_revision_out)
   );

endmodule
